// ===== rtl/led_strip_comet_tail_animator_macros.svh =====
// assertion macros for the comet tail animator
// used by the top level only, expects clk and rst_n in scope
`ifndef LED_STRIP_COMET_TAIL_ANIMATOR_MACROS_SVH
`define LED_STRIP_COMET_TAIL_ANIMATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define LSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsc assertion failed");

// next-cycle implication, checked outside reset
`define LSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsc assertion failed");

`endif

// ===== rtl/lsc_pkg.sv =====
// shared types, constants and tables of the comet tail animator
// no dependencies; used by lsc_ctrl, lsc_datapath and the top level
package lsc_pkg;

    localparam int COLOUR_W     = 8;
    localparam int DIV_W        = 4;
    localparam int RECIP_W      = 17;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_W       = COLOUR_W + RECIP_W;
    localparam int PALETTE_LAST = 21;
    localparam int MOD_STEPS    = 8;

    typedef logic [3*COLOUR_W-1:0] rgb_t;   // {red, green, blue}

    typedef struct packed {
        logic start;      // tick transaction with a tick of 1 taken
        logic mod_step;   // one remainder iteration
        logic mod_last;   // final remainder iteration, load position
        logic issue;      // load one pixel write into the product stage
        logic commit;     // last write of the frame, advance frame state
    } cmd_t;

    typedef struct packed {
        logic tail_in_range;  // tail position below strip length
        logic slot_free;      // product stage can take a write
    } status_t;

    function automatic rgb_t palette_colour(input logic [4:0] idx);
        rgb_t c;
        case (idx)
            5'd0:    c = 24'h800000;
            5'd1:    c = 24'h802000;
            5'd2:    c = 24'h804000;
            5'd3:    c = 24'h806000;
            5'd4:    c = 24'h808000;
            5'd5:    c = 24'h608000;
            5'd6:    c = 24'h408000;
            5'd7:    c = 24'h208000;
            5'd8:    c = 24'h008000;
            5'd9:    c = 24'h008020;
            5'd10:   c = 24'h008040;
            5'd11:   c = 24'h008060;
            5'd12:   c = 24'h008080;
            5'd13:   c = 24'h006080;
            5'd14:   c = 24'h004080;
            5'd15:   c = 24'h002080;
            5'd16:   c = 24'h000080;
            5'd17:   c = 24'h200080;
            5'd18:   c = 24'h400080;
            5'd19:   c = 24'h400060;
            5'd20:   c = 24'h600040;
            5'd21:   c = 24'h600020;
            default: c = '0;
        endcase
        return c;
    endfunction

    // ceil(2^16 / d): (v * recip) >> 16 equals v / d for any 8-bit v
    function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            4'd10:   m = 17'd6554;
            4'd11:   m = 17'd5958;
            4'd12:   m = 17'd5462;
            4'd13:   m = 17'd5042;
            4'd14:   m = 17'd4682;
            4'd15:   m = 17'd4370;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/lsc_ctrl.sv =====
// frame sequencer of the comet tail animator
// depends on lsc_pkg; drives lsc_datapath through cmd_t, reads status_t
module lsc_ctrl #(
    parameter int TRAIL_LENGTH = 8,
    parameter int STEP_W       = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tick,
    output logic                s_tready,
    input  lsc_pkg::status_t    status,
    output lsc_pkg::cmd_t       cmd,
    output logic [STEP_W-1:0]   step
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TRAIL_LENGTH);
    localparam logic [2:0]        MOD_END   = 3'(lsc_pkg::MOD_STEPS - 1);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tick)
                begin
                    cmd.start = 1'b1;
                    step_next = '0;
                    cnt_next  = '0;
                    // tail beyond the strip needs a remainder pass first
                    state_next = status.tail_in_range ? ST_RUN : ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == MOD_END)
                begin
                    cmd.mod_last = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.slot_free)
                begin
                    cmd.issue = 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign step = step_reg;

endmodule

// ===== rtl/lsc_datapath.sv =====
// frame state, position and dimming datapath of the comet tail animator
// depends on lsc_pkg; commanded by lsc_ctrl, drives the output stream
module lsc_datapath #(
    parameter int TRAIL_LENGTH = 8,
    parameter int STEP_W       = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  lsc_pkg::cmd_t       cmd,
    input  logic [STEP_W-1:0]   step,
    output lsc_pkg::status_t    status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int NENT  = TRAIL_LENGTH - 1;
    localparam int IDX_W = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int CW    = lsc_pkg::COLOUR_W;
    localparam int PW    = lsc_pkg::PROD_W;
    localparam int SH    = lsc_pkg::RECIP_SHIFT;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TRAIL_LENGTH);
    localparam logic [4:0]        PAL_LAST  = 5'(lsc_pkg::PALETTE_LAST);

    // frame state
    logic [7:0]           strip_len_reg;
    lsc_pkg::rgb_t        trail_reg [NENT];
    logic [7:0]           tail_reg;
    logic [4:0]           pal_reg;
    logic [7:0]           pos_reg;
    logic [7:0]           mod_rem_reg;
    logic [7:0]           mod_sh_reg;

    // product stage and output register
    logic                 s1_valid_reg;
    logic [PW-1:0]        s1_r_reg, s1_g_reg, s1_b_reg;
    logic [7:0]           s1_pos_reg;
    logic                 s1_first_reg, s1_last_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_pos_reg;
    logic [CW-1:0]        out_r_reg, out_g_reg, out_b_reg;
    logic                 out_first_reg, out_last_reg;

    logic [8:0]                    len9;
    logic [4:0]                    pal_next;
    lsc_pkg::rgb_t                 head_rgb;
    logic [8:0]                    tail_inc;
    logic [7:0]                    tail_next;
    logic [8:0]                    pos_inc;
    logic [7:0]                    pos_next;
    logic [8:0]                    mod_trial;
    logic [7:0]                    mod_rem_next;
    logic [IDX_W-1:0]              trail_idx;
    lsc_pkg::rgb_t                 sel_rgb;
    logic [lsc_pkg::DIV_W-1:0]     sel_div;
    logic [lsc_pkg::RECIP_W-1:0]   rcp;
    logic                          out_adv;

    // a length of zero means 256 pixels
    assign len9      = (strip_len_reg == 8'd0) ? 9'd256 : {1'b0, strip_len_reg};
    assign pal_next  = (pal_reg == PAL_LAST) ? 5'd0 : pal_reg + 5'd1;
    assign head_rgb  = lsc_pkg::palette_colour(pal_next);
    assign tail_inc  = {1'b0, tail_reg} + 9'd1;
    assign tail_next = (tail_inc >= len9) ? 8'd0 : tail_inc[7:0];
    assign pos_inc   = {1'b0, pos_reg} + 9'd1;
    assign pos_next  = (pos_inc == len9) ? 8'd0 : pos_inc[7:0];

    // restoring remainder, one tail bit per cycle
    assign mod_trial    = {mod_rem_reg, mod_sh_reg[7]};
    assign mod_rem_next = (mod_trial >= len9) ? 8'(mod_trial - len9) : mod_trial[7:0];

    assign trail_idx = IDX_W'(step - STEP_W'(1));

    always_comb
    begin
        if (step == '0)
        begin
            sel_rgb = '0;
            sel_div = lsc_pkg::DIV_W'(1);
        end
        else if (step == STEP_LAST)
        begin
            sel_rgb = head_rgb;
            sel_div = lsc_pkg::DIV_W'(1);
        end
        else
        begin
            // oldest entry gets the largest divisor
            sel_rgb = trail_reg[trail_idx];
            sel_div = lsc_pkg::DIV_W'(STEP_LAST - step);
        end
    end

    assign rcp = lsc_pkg::recip(sel_div);

    assign out_adv = s1_valid_reg && (!out_valid_reg || m_tready);

    assign status.tail_in_range = ({1'b0, tail_reg} < len9);
    assign status.slot_free     = !s1_valid_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_len_reg <= 8'd16;
        end
        else if (cfg_we)
        begin
            strip_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NENT; i++)
            begin
                trail_reg[i] <= '0;
            end
            tail_reg <= '0;
            pal_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < NENT - 1; i++)
            begin
                trail_reg[i] <= trail_reg[i + 1];
            end
            trail_reg[NENT - 1] <= head_rgb;
            tail_reg            <= tail_next;
            pal_reg             <= pal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mod_rem_reg <= '0;
            mod_sh_reg  <= tail_reg;
            if (status.tail_in_range)
            begin
                pos_reg <= tail_reg;
            end
        end
        else if (cmd.mod_step)
        begin
            mod_rem_reg <= mod_rem_next;
            mod_sh_reg  <= {mod_sh_reg[6:0], 1'b0};
            if (cmd.mod_last)
            begin
                pos_reg <= mod_rem_next;
            end
        end
        else if (cmd.issue)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            s1_r_reg     <= PW'(sel_rgb[23:16]) * PW'(rcp);
            s1_g_reg     <= PW'(sel_rgb[15:8]) * PW'(rcp);
            s1_b_reg     <= PW'(sel_rgb[7:0]) * PW'(rcp);
            s1_pos_reg   <= pos_reg;
            s1_first_reg <= (step == '0);
            s1_last_reg  <= (step == STEP_LAST);
        end
        if (out_adv)
        begin
            out_pos_reg   <= s1_pos_reg;
            out_r_reg     <= s1_r_reg[SH +: CW];
            out_g_reg     <= s1_g_reg[SH +: CW];
            out_b_reg     <= s1_b_reg[SH +: CW];
            out_first_reg <= s1_first_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_b_reg, out_g_reg, out_r_reg, out_pos_reg};
    assign m_tuser  = out_first_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/led_strip_comet_tail_animator.sv =====
// comet tail animator for an addressable led strip
// Input stream: one transaction per frame tick (s_tdata bit 0 = tick). A tick of 0 is
// taken and ignored. Each tick of 1 yields TRAIL_LENGTH+1 pixel writes on the output
// stream: first the blanked tail pixel (tuser high), then the dimmed trail entries,
// oldest first, then the new head colour (tlast high).
// Pipeline: each write passes the product stage and the result register before m_tvalid.
// Throughput: one write per cycle while the output is not stalled; the next tick is
// taken in the cycle after the head write is issued. If strip_length was lowered to or
// below the tail position, a bit-serial remainder unit runs before the frame starts.
// Output stall: the result register holds while m_tready is low; the one-entry product
// stage behind it fills and the sequencer waits, nothing is dropped.
// Reset: trail cleared to black, tail position and palette index to 0, strip length 16.
// Configuration: cfg_we writes strip_length (0 means 256); write only while idle.
// Datapath: reciprocal multiply per channel (8x17), registered before the output stage.
module led_strip_comet_tail_animator #(
    parameter int TRAIL_LENGTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // strip_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [0] tick, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [7:0] pixel_index, [15:8] red, [23:16] green,
                                       // [31:24] blue
    output logic        m_tuser,       // frame_start
    output logic        m_tlast        // last
);

    localparam int STEP_W = $clog2(TRAIL_LENGTH + 1);

    lsc_pkg::cmd_t      cmd;
    lsc_pkg::status_t   status;
    logic [STEP_W-1:0]  step;

    lsc_ctrl #(
        .TRAIL_LENGTH (TRAIL_LENGTH),
        .STEP_W       (STEP_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tick   (s_tdata[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .step     (step)
    );

    lsc_datapath #(
        .TRAIL_LENGTH (TRAIL_LENGTH),
        .STEP_W       (STEP_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .step      (step),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`include "led_strip_comet_tail_animator_macros.svh"

    // sequencer only loads the product stage when it has room
    `LSC_ASSERT_NOW(a_issue_has_slot, cmd.issue, status.slot_free)
    // remainder iterations and pixel issue never overlap
    `LSC_ASSERT_NOW(a_mod_excludes_issue, cmd.mod_step, !cmd.issue)
    // a tick of 1 always makes the block busy for its frame
    `LSC_ASSERT_NEXT(a_tick_goes_busy, s_tvalid && s_tready && s_tdata[0], !s_tready)
    // the frame state only advances on the head write
    `LSC_ASSERT_NOW(a_commit_on_issue, cmd.commit, cmd.issue)

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the comet tail animator: ticks in, pixel writes out
// depends only on the rtl top level led_strip_comet_tail_animator
`timescale 1ns / 100ps

module tb_top;

    localparam int TRAIL_LEN  = 8;
    localparam int HUE_LAST   = 21;
    localparam int SETTLE     = 24;
    localparam int MAX_PRINTS = 40;
    localparam int HALF_PHASE = 40;

    // palette, {red, green, blue}
    localparam logic [23:0] HUES [22] = '{
        24'h800000, 24'h802000, 24'h804000, 24'h806000, 24'h808000, 24'h608000,
        24'h408000, 24'h208000, 24'h008000, 24'h008020, 24'h008040, 24'h008060,
        24'h008080, 24'h006080, 24'h004080, 24'h002080, 24'h000080, 24'h200080,
        24'h400080, 24'h400060, 24'h600040, 24'h600020
    };

    typedef struct {
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
        logic       last;
    } pixel_write_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [0] tick, [7:1] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [7:0] pixel_index, [15:8] red, [23:16] green,
                                     // [31:24] blue
    logic        m_tuser;            // frame_start
    logic        m_tlast;            // last

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    class comet_scoreboard;
        logic [7:0]   strip_len;
        logic [23:0]  trail [TRAIL_LEN-1];
        logic [7:0]   tail_pos;
        logic [4:0]   hue_idx;
        pixel_write_t expected_writes [$];
        int           errors;
        int           writes_seen;

        function new();
            strip_len = 8'd16;
            foreach (trail[i])
                trail[i] = '0;
            tail_pos    = '0;
            hue_idx     = '0;
            errors      = 0;
            writes_seen = 0;
        endfunction

        function void set_length(logic [7:0] len);
            strip_len = len;
        endfunction

        function void push_write(int unsigned idx, logic [23:0] rgb, logic first, logic fin);
            pixel_write_t w;
            w.index       = idx[7:0];
            w.red         = rgb[23:16];
            w.green       = rgb[15:8];
            w.blue        = rgb[7:0];
            w.frame_start = first;
            w.last        = fin;
            expected_writes.push_back(w);
        endfunction

        // one accepted tick transaction: for a tick of 1 predict the whole frame and advance the state
        function void note_tick(logic tick);
            int unsigned len;
            int unsigned base;
            int unsigned div;
            logic [23:0] dimmed;
            if (!tick)
                return;
            len  = (strip_len == 0) ? 256 : strip_len;
            base = tail_pos;
            push_write(base % len, 24'h0, 1'b1, 1'b0);
            for (int i = 0; i < TRAIL_LEN - 1; i++)
            begin
                div    = TRAIL_LEN - 1 - i;
                dimmed = {8'(trail[i][23:16] / div), 8'(trail[i][15:8] / div),
                          8'(trail[i][7:0] / div)};
                push_write((base + i + 1) % len, dimmed, 1'b0, 1'b0);
            end
            for (int i = 0; i < TRAIL_LEN - 2; i++)
                trail[i] = trail[i + 1];
            hue_idx = (hue_idx == HUE_LAST) ? 5'd0 : hue_idx + 5'd1;
            trail[TRAIL_LEN-2] = HUES[hue_idx];
            push_write((base + TRAIL_LEN) % len, HUES[hue_idx], 1'b0, 1'b1);
            // a tail left beyond a shortened strip falls back to 0 here
            tail_pos = (base + 1 >= len) ? 8'd0 : 8'(base + 1);
        endfunction

        task report(string what);
            if (errors < MAX_PRINTS)
                $display("pixel write %0d: %s", writes_seen, what);
            errors++;
        endtask

        task check_write(logic [31:0] data, logic first, logic fin);
            pixel_write_t w;
            writes_seen++;
            if (expected_writes.size() == 0)
            begin
                report("transaction with no write expected");
                return;
            end
            w = expected_writes.pop_front();
            if (data[7:0] !== w.index)
                report($sformatf("pixel_index %0d, expected %0d", data[7:0], w.index));
            if (data[15:8] !== w.red)
                report($sformatf("red %0d, expected %0d", data[15:8], w.red));
            if (data[23:16] !== w.green)
                report($sformatf("green %0d, expected %0d", data[23:16], w.green));
            if (data[31:24] !== w.blue)
                report($sformatf("blue %0d, expected %0d", data[31:24], w.blue));
            if (first !== w.frame_start)
                report($sformatf("frame_start %0b, expected %0b", first, w.frame_start));
            if (fin !== w.last)
                report($sformatf("last %0b, expected %0b", fin, w.last));
        endtask
    endclass

    comet_scoreboard sb = new();

    led_strip_comet_tail_animator #(
        .TRAIL_LENGTH (TRAIL_LEN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_tick(s_tdata[0]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_write(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_tick(input logic tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, tick};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_ticks(input int count);
        repeat (count)
            send_tick($urandom_range(9) != 0);
    endtask

    // stop sending and wait until every predicted write has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_length(input logic [7:0] len);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_length(len);
    endtask

    initial
    begin
        logic [7:0] first_len;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length, ignored zero ticks around a few frames
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        // length zero means a 256 pixel strip
        write_length(8'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        // strips shorter than a frame, positions repeat
        write_length(8'd1);
        send_tick(1'b1);
        send_tick(1'b1);
        write_length(8'd8);
        send_tick(1'b1);
        send_tick(1'b1);
        write_length(8'd255);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: first_len = 8'd255;
                1: first_len = 8'd0;
                2: first_len = 8'($urandom_range(9, 254));
                default: first_len = 8'd9;
            endcase
            write_length(first_len);
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            send_random_ticks(HALF_PHASE);
            // shorter strip, usually leaving the tail beyond its end
            write_length(8'($urandom_range(1, 30)));
            send_random_ticks(HALF_PHASE);
        end

        drain();
        if (sb.errors == 0 && sb.expected_writes.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
